FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the circular deque RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque package
// Codes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int unsigned ACT_W  = 3;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned WORD_W = 32;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_LIST       = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_PUSH_FRONT,
    DP_PUSH_REAR,
    DP_POP_FRONT,
    DP_POP_REAR,
    DP_LIST_START,
    DP_LIST_NEXT
  } dp_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_LIST_RD,
    S_RESULT,
    S_LIST_OUT
  } ctl_state_e;

  typedef struct packed {
    dp_op_e  op;
    logic    res_load;
    status_e res_status;
    logic    res_use_rd;
    logic    res_last;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic walk_last;
    logic res_last;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/cdq_if.sv
// ----------------------------------------------------------------------------
// Circular deque channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface cdq_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface cdq_rsp_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic signed [31:0] data;
  logic              last;

  modport source (output valid, output status, output data, output last, input ready);
  modport sink   (input valid, input status, input data, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// Circular deque controller
// Sequences one request at a time and drives the datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cdq_ctrl
  import cdq_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  input  wire logic [ACT_W-1:0] req_action_i,
  output logic                  req_ready_o,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  output dp_cmd_t               cmd_o,
  input  wire dp_sts_t          sts_i
);

  ctl_state_e state_q, state_d;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid_i && (state_q == S_IDLE);
  assign rsp_fire = rsp_ready_i && ((state_q == S_RESULT) || (state_q == S_LIST_OUT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          unique case (req_action_i)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: state_d = S_RESULT;
            ACT_POP_FRONT, ACT_POP_REAR:   state_d = sts_i.empty ? S_RESULT : S_POP_RD;
            ACT_LIST:                      state_d = sts_i.empty ? S_RESULT : S_LIST_RD;
            default:                       state_d = S_IDLE;
          endcase
        end
      end
      S_POP_RD:  state_d = S_RESULT;
      S_LIST_RD: state_d = S_LIST_OUT;
      S_RESULT: begin
        if (rsp_fire) begin
          state_d = S_IDLE;
        end
      end
      S_LIST_OUT: begin
        if (rsp_fire) begin
          state_d = sts_i.res_last ? S_IDLE : S_LIST_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o       = (state_q == S_IDLE);
    rsp_valid_o       = (state_q == S_RESULT) || (state_q == S_LIST_OUT);
    cmd_o.op          = DP_NONE;
    cmd_o.res_load    = 1'b0;
    cmd_o.res_status  = ST_OK;
    cmd_o.res_use_rd  = 1'b0;
    cmd_o.res_last    = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          unique case (req_action_i)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
              cmd_o.res_load = 1'b1;
              if (sts_i.full) begin
                cmd_o.res_status = ST_OVERFLOW;
              end else begin
                cmd_o.op = (req_action_i == ACT_PUSH_FRONT) ? DP_PUSH_FRONT : DP_PUSH_REAR;
              end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
              if (sts_i.empty) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_UNDERFLOW;
              end else begin
                cmd_o.op = (req_action_i == ACT_POP_FRONT) ? DP_POP_FRONT : DP_POP_REAR;
              end
            end
            ACT_LIST: begin
              if (sts_i.empty) begin
                cmd_o.res_load   = 1'b1;
                cmd_o.res_status = ST_EMPTY;
              end else begin
                cmd_o.op = DP_LIST_START;
              end
            end
            default: cmd_o.op = DP_NONE;
          endcase
        end
      end
      S_POP_RD: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_use_rd = 1'b1;
      end
      S_LIST_RD: begin
        cmd_o.res_load   = 1'b1;
        cmd_o.res_use_rd = 1'b1;
        cmd_o.res_last   = sts_i.walk_last;
      end
      S_RESULT: cmd_o.op = DP_NONE;
      S_LIST_OUT: begin
        if (rsp_fire && !sts_i.res_last) begin
          cmd_o.op = DP_LIST_NEXT;
        end
      end
      default: cmd_o.op = DP_NONE;
    endcase
  end

  // A new request is never taken while a result is on offer.
  `ASSERT_NEVER(a_no_overlap, clk_i, rst_ni, req_ready_o && rsp_valid_o, "request taken while result pending")
  // A delivered last result always returns the controller to idle.
  `ASSERT_CLK(a_last_to_idle, clk_i, rst_ni, (rsp_fire && sts_i.res_last) |=> (state_q == S_IDLE), "no return to idle after last result")

endmodule

`default_nettype wire

FILE: rtl/cdq_datapath.sv
// ----------------------------------------------------------------------------
// Circular deque datapath
// Slot memory, ring pointers, occupancy, list walker and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cdq_datapath
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [WORD_W-1:0] value_i,
  input  wire dp_cmd_t                  cmd_i,
  output dp_sts_t                       sts_o,
  output logic [STAT_W-1:0]             res_status_o,
  output logic signed [WORD_W-1:0]      res_data_o,
  output logic                          res_last_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    return (p == '0) ? LAST_PTR : p - PTR_W'(1);
  endfunction

  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rd_data_q;

  logic [PTR_W-1:0] head_q, head_d;
  logic [PTR_W-1:0] tail_q, tail_d;
  logic [PTR_W-1:0] walk_q, walk_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] rem_q, rem_d;

  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic             rd_en;
  logic [PTR_W-1:0] rd_addr;
  logic             empty;

  logic [STAT_W-1:0]        res_status_q;
  logic signed [WORD_W-1:0] res_data_q;
  logic                     res_last_q;

  assign empty = (count_q == '0);

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    walk_d  = walk_q;
    count_d = count_q;
    rem_d   = rem_q;
    wr_en   = 1'b0;
    wr_addr = '0;
    rd_en   = 1'b0;
    rd_addr = head_q;
    unique case (cmd_i.op)
      DP_PUSH_FRONT: begin
        wr_en   = 1'b1;
        count_d = count_q + CNT_W'(1);
        if (empty) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          head_d = ptr_prev(head_q);
        end
        wr_addr = head_d;
      end
      DP_PUSH_REAR: begin
        wr_en   = 1'b1;
        count_d = count_q + CNT_W'(1);
        if (empty) begin
          head_d  = '0;
          tail_d  = '0;
          wr_addr = '0;
        end else begin
          tail_d  = ptr_next(tail_q);
          wr_addr = tail_d;
        end
      end
      DP_POP_FRONT: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
        count_d = count_q - CNT_W'(1);
        head_d  = ptr_next(head_q);
        if (count_q == CNT_W'(1)) begin
          head_d = '0;
          tail_d = '0;
        end
      end
      DP_POP_REAR: begin
        rd_en   = 1'b1;
        rd_addr = tail_q;
        count_d = count_q - CNT_W'(1);
        tail_d  = ptr_prev(tail_q);
        if (count_q == CNT_W'(1)) begin
          head_d = '0;
          tail_d = '0;
        end
      end
      DP_LIST_START: begin
        rd_en   = 1'b1;
        rd_addr = head_q;
        walk_d  = head_q;
        rem_d   = count_q;
      end
      DP_LIST_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = ptr_next(walk_q);
        walk_d  = ptr_next(walk_q);
        rem_d   = rem_q - CNT_W'(1);
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      walk_q  <= '0;
      count_q <= '0;
      rem_q   <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      walk_q  <= walk_d;
      count_q <= count_d;
      rem_q   <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_data_q   <= cmd_i.res_use_rd ? rd_data_q : '0;
      res_last_q   <= cmd_i.res_last;
    end
  end

  assign sts_o.full      = (count_q == CNT_W'(DEPTH));
  assign sts_o.empty     = empty;
  assign sts_o.walk_last = (rem_q == CNT_W'(1));
  assign sts_o.res_last  = res_last_q;

  assign res_status_o = res_status_q;
  assign res_data_o   = res_data_q;
  assign res_last_o   = res_last_q;

  `ASSERT_CLK(a_cnt_le_depth, clk_i, rst_ni, count_q <= CNT_W'(DEPTH), "occupancy beyond depth")
  `ASSERT_CLK(a_empty_ptrs, clk_i, rst_ni, empty |-> ((head_q == '0) && (tail_q == '0)), "pointers not parked on empty")
  `ASSERT_CLK(a_push_count, clk_i, rst_ni, ((cmd_i.op == DP_PUSH_FRONT) || (cmd_i.op == DP_PUSH_REAR)) |=> (count_q == $past(count_q) + CNT_W'(1)), "push did not grow occupancy")

endmodule

`default_nettype wire

FILE: rtl/circular_deque_top.sv
// ----------------------------------------------------------------------------
// Circular deque top level
// Ring-buffer double-ended queue of DEPTH signed 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one request per transaction: action (push front, push rear,
//   pop front, pop rear, list) and the value to push.
//   rsp_o returns status, data and last for every result of that request.
//   Requests are served one at a time; req_i.ready is high only while idle.
//   Push, overflow, underflow and empty list: result is offered in the cycle
//   after the request transaction.
//   Pop: the result passes the registered read of the slot memory and then
//   the result register before it is offered.
//   List: each entry is read from the slot memory and then offered; the next
//   entry is read only once the current one is delivered.
//   Unused action codes are taken and produce no result.
//   If the receiver stalls, the result register holds its value and no new
//   request is taken until the final result of the current one is delivered.
//   Reset empties the deque; slot contents are not cleared and need no pass.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque_top
  import cdq_pkg::*;
#(
  parameter int unsigned DEPTH = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cdq_req_if.sink    req_i,
  cdq_rsp_if.source  rsp_o
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  cdq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_action_i (req_i.action),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .cmd_o        (dp_cmd),
    .sts_i        (dp_sts)
  );

  cdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .value_i      (req_i.value),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts),
    .res_status_o (rsp_o.status),
    .res_data_o   (rsp_o.data),
    .res_last_o   (rsp_o.last)
  );

endmodule

`default_nettype wire

FILE: test/circular_deque_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular deque testbench
// Runs a short list of directed requests, then about 200 random requests.
// Random requests alternate between filling and draining the deque, so that
// full, empty and index wrap-around occur many times. Every result
// transaction is compared with a software model of the ring buffer. The
// request side sends in bursts with random gaps, and the response side
// stalls on its own changing pattern.
// ----------------------------------------------------------------------------

module circular_deque_top_tb;
  import cdq_pkg::*;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned RANDOM_ITEMS = 190;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned NUM_DIRECTED = 23;

  localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_C = 3'd7;

  typedef struct {
    status_e           status;
    logic [WORD_W-1:0] data;
    logic              last;
  } deque_result_t;

  typedef struct {
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] value;
    bit                typed;
    status_e           status;
    logic [WORD_W-1:0] data;
  } directed_row_t;

  typedef enum {PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_COMB} pace_e;

  logic clk;
  logic rst_n;

  cdq_req_if req ();
  cdq_rsp_if rsp ();

  circular_deque_top #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req),
    .rsp_o (rsp)
  );

  logic [WORD_W-1:0] ring_slots [DEPTH];
  int unsigned       front_idx;
  int unsigned       rear_idx;
  int unsigned       fill_count;

  deque_result_t expected_results [$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  int unsigned   burst_left;

  directed_row_t directed_steps [NUM_DIRECTED] = '{
    '{ACT_LIST,       32'h0000_0000, 1'b1, ST_EMPTY,     32'h0000_0000},
    '{ACT_POP_FRONT,  32'h1234_5678, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
    '{ACT_POP_REAR,   32'hFFFF_FFFF, 1'b1, ST_UNDERFLOW, 32'h0000_0000},
    '{ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK,        32'h0000_0000},
    '{ACT_POP_REAR,   32'h0000_0000, 1'b1, ST_OK,        32'h7FFF_FFFF},
    '{ACT_PUSH_REAR,  32'h8000_0000, 1'b1, ST_OK,        32'h0000_0000},
    '{ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, ST_OK,        32'h0000_0000},
    '{ACT_PUSH_REAR,  32'h0000_0000, 1'b1, ST_OK,        32'h0000_0000},
    '{ACT_PUSH_FRONT, 32'h5555_5555, 1'b1, ST_OK,        32'h0000_0000},
    '{ACT_PUSH_REAR,  32'hAAAA_AAAA, 1'b1, ST_OK,        32'h0000_0000},
    '{ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK,        32'h0000_0000},
    '{ACT_PUSH_REAR,  32'h0000_0001, 1'b1, ST_OK,        32'h0000_0000},
    '{ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_OK,        32'h0000_0000},
    '{ACT_PUSH_FRONT, 32'hDEAD_BEEF, 1'b1, ST_OVERFLOW,  32'h0000_0000},
    '{ACT_PUSH_REAR,  32'h0BAD_F00D, 1'b1, ST_OVERFLOW,  32'h0000_0000},
    '{ACT_LIST,       32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000},
    '{ACT_SPARE_A,    32'h0000_0001, 1'b0, ST_OK,        32'h0000_0000},
    '{ACT_SPARE_B,    32'hFFFF_FFFF, 1'b0, ST_OK,        32'h0000_0000},
    '{ACT_SPARE_C,    32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000},
    '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000},
    '{ACT_POP_REAR,   32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000},
    '{ACT_LIST,       32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000},
    '{ACT_POP_FRONT,  32'h0000_0000, 1'b0, ST_OK,        32'h0000_0000}
  };

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  function automatic void expect_result(input status_e st, input logic [WORD_W-1:0] dat,
                                        input logic lst);
    deque_result_t r;
    r.status = st;
    r.data   = dat;
    r.last   = lst;
    expected_results.push_back(r);
  endfunction

  function automatic void predict_request(input logic [ACT_W-1:0] act,
                                          input logic [WORD_W-1:0] val);
    logic [WORD_W-1:0] word;
    int unsigned       k;
    int unsigned       idx;
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (fill_count >= DEPTH) begin
          expect_result(ST_OVERFLOW, '0, 1'b1);
        end else begin
          if (fill_count == 0) begin
            front_idx     = 0;
            rear_idx      = 0;
            ring_slots[0] = val;
          end else if (act == ACT_PUSH_FRONT) begin
            front_idx             = (front_idx + DEPTH - 1) % DEPTH;
            ring_slots[front_idx] = val;
          end else begin
            rear_idx             = (rear_idx + 1) % DEPTH;
            ring_slots[rear_idx] = val;
          end
          fill_count++;
          expect_result(ST_OK, '0, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (fill_count == 0) begin
          expect_result(ST_UNDERFLOW, '0, 1'b1);
        end else begin
          if (act == ACT_POP_FRONT) begin
            word      = ring_slots[front_idx];
            front_idx = (front_idx + 1) % DEPTH;
          end else begin
            word     = ring_slots[rear_idx];
            rear_idx = (rear_idx + DEPTH - 1) % DEPTH;
          end
          fill_count--;
          if (fill_count == 0) begin
            front_idx = 0;
            rear_idx  = 0;
          end
          expect_result(ST_OK, word, 1'b1);
        end
      end
      ACT_LIST: begin
        if (fill_count == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          idx = front_idx;
          for (k = 0; k < fill_count; k++) begin
            expect_result(ST_OK, ring_slots[idx], (k + 1 == fill_count));
            idx = (idx + 1) % DEPTH;
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '1;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic pause_sender(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      req.valid  = 1'b0;
      req.action = ACT_W'($urandom);
      req.value  = $urandom;
    end
  endtask

  task automatic pace_sender();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
    burst_left--;
  endtask

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] val);
    @(negedge clk);
    req.valid  = 1'b1;
    req.action = act;
    req.value  = val;
    forever begin
      @(posedge clk);
      if (req.ready) break;
    end
    predict_request(act, val);
  endtask

  always @(posedge clk) begin : rsp_check
    deque_result_t want;
    if (rst_n && rsp.valid && rsp.ready) begin
      if (expected_results.size() == 0) begin
        note_failure($sformatf("unexpected result status=%0d data=%h last=%0d",
                               rsp.status, rsp.data, rsp.last));
      end else begin
        want = expected_results.pop_front();
        if (rsp.status !== want.status || rsp.data !== want.data || rsp.last !== want.last) begin
          note_failure($sformatf("expected status=%0d data=%h last=%0d, got %0d %h %0d",
                                 want.status, want.data, want.last,
                                 rsp.status, rsp.data, rsp.last));
        end
      end
    end
  end

  initial begin : rsp_pacer
    pace_e       mode;
    int unsigned span;
    int unsigned phase;
    rsp.ready = 1'b0;
    forever begin
      mode = pace_e'($urandom_range(0, 3));
      span = $urandom_range(16, 64);
      for (phase = 0; phase < span; phase++) begin
        @(negedge clk);
        case (mode)
          PACE_OPEN:   rsp.ready = 1'b1;
          PACE_COIN:   rsp.ready = 1'($urandom_range(0, 1));
          PACE_SPARSE: rsp.ready = ($urandom_range(0, 5) == 0);
          default:     rsp.ready = ((phase % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    deque_result_t     dropped;
    int unsigned       row;
    int unsigned       done_items;
    int unsigned       roll;
    bit                filling;
    logic [ACT_W-1:0]  act;
    req.valid      = 1'b0;
    req.action     = ACT_PUSH_FRONT;
    req.value      = '0;
    rst_n          = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 0;
    fill_count     = 0;
    front_idx      = 0;
    rear_idx       = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    for (row = 0; row < NUM_DIRECTED; row++) begin
      pace_sender();
      send_request(directed_steps[row].action, directed_steps[row].value);
      if (directed_steps[row].typed) begin
        dropped = expected_results.pop_back();
        expect_result(directed_steps[row].status, directed_steps[row].data, 1'b1);
      end
    end

    done_items = 0;
    filling    = 1'b1;
    while (done_items < RANDOM_ITEMS) begin
      if (fill_count == DEPTH) filling = 1'b0;
      if (fill_count == 0) filling = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        act = ACT_W'(ACT_SPARE_A + $urandom_range(0, 2));
      end else begin
        done_items++;
        if (roll < 16) begin
          act = ACT_LIST;
        end else if (($urandom_range(0, 3) != 0) == filling) begin
          act = $urandom_range(0, 1) ? ACT_PUSH_REAR : ACT_PUSH_FRONT;
        end else begin
          act = $urandom_range(0, 1) ? ACT_POP_REAR : ACT_POP_FRONT;
        end
      end
      pace_sender();
      send_request(act, pick_word());
    end
    @(negedge clk);
    req.valid = 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (4 * DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/cdq_ctrl.sv
rtl/cdq_datapath.sv
rtl/circular_deque_top.sv
test/circular_deque_top_tb.sv
